@@ hdl/fcf_pkg.sv @@
package fcf_pkg;

  // Fixed field widths of the ports.
  localparam int TAPCNT_W   = 6;
  localparam int SHIFT_W    = 5;
  localparam int TAPIDX_W   = 5;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST    = 6'd32;
  localparam logic [SHIFT_W-1:0]  RESULT_SHIFT_RST = 5'd15;

  // Item opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic data_vld;
    logic round;
  } mac_ctl_t;

endpackage

@@ hdl/fcf_mac.sv @@
module fcf_mac
  import fcf_pkg::*;
#(
  parameter int MAX_TAPS     = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mac_ctl_t                       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] coef_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic        [SHIFT_W-1:0]      shift_i,
  output logic                           prod_vld_o,
  output logic        [OUT_W-1:0]        filtered_o,
  output logic                           sat_o
);

  // The accumulator holds the exact sum plus the rounding term, and never
  // goes beyond 64 bits, where the sum wraps.
  localparam int PROD_W  = 2 * SAMPLE_WIDTH;
  localparam int ACC_RAW = PROD_W + $clog2(MAX_TAPS + 1) + 1;
  localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ((ACC_RAW < 33) ? 33 : ACC_RAW);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shifted_r;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  sat_val;

  // Product stage: one multiply per cycle, registered before the add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.data_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.data_vld) begin
      prod_r <= coef_i * sample_i;
    end
  end

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Half an output LSB is added before the arithmetic shift.
  always_comb begin
    rnd = '0;
    if (shift_i != '0) begin
      rnd = ACC_W'(1) << (shift_i - SHIFT_W'(1));
    end
    sum     = acc_r + rnd;
    shifted = sum >>> shift_i;
  end

  always_ff @(posedge clk) begin
    if (ctl.round) begin
      shifted_r <= shifted;
    end
  end

  // Clip to the signed sample range.
  always_comb begin
    sat_val = shifted_r;
    sat_o   = 1'b0;
    if (shifted_r > SAT_HI) begin
      sat_val = SAT_HI;
      sat_o   = 1'b1;
    end else if (shifted_r < SAT_LO) begin
      sat_val = SAT_LO;
      sat_o   = 1'b1;
    end
  end

  assign filtered_o = sat_val[OUT_W-1:0];
  assign prod_vld_o = prod_vld_r;

endmodule

@@ hdl/fir_convolution_filter_core.sv @@
// Direct-form FIR filter giving the full linear convolution of a sample
// stream with a loaded coefficient set.
// Input channel (in_valid/in_stall): a load beat (opcode 0) writes one
// coefficient and gives no result; a sample beat (opcode 1) shifts the
// sample into the delay line and gives one result. A sample beat with
// in_last_sample set also gives N-1 tail results (N as below), the final one
// marked by out_last_result, and then leaves the delay line cleared.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 is tap_count,
// index 1 is result_shift; write them only while the block is idle.
// Operation: one shared multiplier works through one tap per cycle, over the
// N taps in use (tap_count, zero read as one, capped at MAX_TAPS). A load
// beat leaves in_stall low. in_stall is high while a sample is being worked
// on, tail included.
// The result register holds a beat while out_stall is high; the next sample
// may be taken meanwhile, and its result waits until the register is free.
// Reset clears the delay line, tap_count to 32 and result_shift to 15;
// coefficients hold no defined value until loaded.
module fir_convolution_filter_core
  import fcf_pkg::*;
#(
  parameter int MAX_TAPS     = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic        [TAPIDX_W-1:0]   in_tap_index,
  input  logic signed [IN_W-1:0]       in_value,
  input  logic                         in_last_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      out_filtered,
  output logic                         out_last_result,
  output logic                         out_saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(MAX_TAPS - 1);

  state_t state_r, state_nxt;

  logic [TAPCNT_W-1:0]     tap_count_r;
  logic [SHIFT_W-1:0]      result_shift_r;

  logic [SAMPLE_WIDTH-1:0] dly_mem [MAX_TAPS];
  logic [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]     dly_vld_r;
  logic [AW-1:0]           hp_r, hp_nxt;
  logic [AW-1:0]           rp_r;
  logic [CW-1:0]           iss_r;
  logic [CW-1:0]           taps_r;
  logic [CW-1:0]           tail_r;
  logic                    fin_r;
  logic [CW-1:0]           taps_use;

  logic [SAMPLE_WIDTH-1:0] dly_q_r;
  logic                    dly_ok_r;
  logic [SAMPLE_WIDTH-1:0] coef_q_r;
  logic                    rd_vld_r;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_filtered_r;
  logic                    out_last_r;
  logic                    out_sat_r;

  logic                    in_accept;
  logic                    coef_we;
  logic                    shift_en;
  logic                    shift_zero;
  logic                    rd_en;
  logic                    out_load;
  logic                    clr_vld;
  logic                    last_flag;
  logic [SAMPLE_WIDTH-1:0] samp;
  logic [SAMPLE_WIDTH-1:0] shift_data;
  logic [SAMPLE_WIDTH-1:0] mac_sample;
  mac_ctl_t                mac_ctl;
  logic                    prod_vld;
  logic [OUT_W-1:0]        mac_filtered;
  logic                    mac_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The incoming value, sign-extended or truncated to the sample width.
  assign samp = SAMPLE_WIDTH'(in_value);

  // Taps in use: zero counts as one, and the count is capped at the depth.
  always_comb begin
    int tu;
    tu = int'(tap_count_r);
    if (tu == 0) begin
      tu = 1;
    end
    if (tu > MAX_TAPS) begin
      tu = MAX_TAPS;
    end
    taps_use = CW'(tu);
  end

  // Circular delay line: the newest sample sits at the head pointer.
  assign hp_nxt     = (hp_r == LAST_PTR) ? '0 : hp_r + AW'(1);
  assign shift_data = shift_zero ? '0 : samp;
  assign last_flag  = fin_r && (tail_r == '0);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r    <= TAP_COUNT_RST;
      result_shift_r <= RESULT_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAP_COUNT:    tap_count_r    <= cfg_data[TAPCNT_W-1:0];
        REG_RESULT_SHIFT: result_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_opcode == OP_SAMPLE)) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (iss_r == taps_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !prod_vld) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = (tail_r != '0) ? ST_MAC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    coef_we          = 1'b0;
    shift_en         = 1'b0;
    shift_zero       = 1'b0;
    rd_en            = 1'b0;
    out_load         = 1'b0;
    clr_vld          = 1'b0;
    mac_ctl.clear    = 1'b0;
    mac_ctl.data_vld = rd_vld_r;
    mac_ctl.round    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_opcode == OP_LOAD) begin
            coef_we = (int'(in_tap_index) < MAX_TAPS);
          end else begin
            shift_en = 1'b1;
          end
        end
      end
      ST_MAC: begin
        rd_en         = 1'b1;
        mac_ctl.clear = (iss_r == '0);
      end
      ST_DRAIN: ;
      ST_ROUND: mac_ctl.round = 1'b1;
      ST_EMIT: begin
        out_load = !out_valid_r || !out_stall;
        if (out_load && (tail_r != '0)) begin
          shift_en   = 1'b1;
          shift_zero = 1'b1;
        end
        clr_vld = out_load && last_flag;
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dly_vld_r <= '0;
      hp_r      <= '0;
      rd_vld_r  <= 1'b0;
      tail_r    <= '0;
      fin_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (shift_en) begin
        hp_r              <= hp_nxt;
        dly_vld_r[hp_nxt] <= 1'b1;
      end
      if (clr_vld) begin
        dly_vld_r <= '0;
      end
      if (shift_en && !shift_zero) begin
        fin_r  <= in_last_sample;
        tail_r <= in_last_sample ? taps_use - CW'(1) : '0;
      end else if (shift_zero) begin
        tail_r <= tail_r - CW'(1);
      end
    end
  end

  // Tap walk: pointers and counts for the shared unit.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rp_r  <= hp_nxt;
      iss_r <= '0;
    end else if (rd_en) begin
      rp_r  <= (rp_r == '0) ? LAST_PTR : rp_r - AW'(1);
      iss_r <= iss_r + CW'(1);
    end
    if (shift_en && !shift_zero) begin
      taps_r <= taps_use;
    end
  end

  // Coefficient and delay line memories, with registered reads.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[AW'(in_tap_index)] <= samp;
    end
    if (shift_en) begin
      dly_mem[hp_nxt] <= shift_data;
    end
    if (rd_en) begin
      coef_q_r <= coef_mem[iss_r[AW-1:0]];
      dly_q_r  <= dly_mem[rp_r];
      dly_ok_r <= dly_vld_r[rp_r];
    end
  end

  // An entry cleared since its last write reads as zero.
  assign mac_sample = dly_ok_r ? dly_q_r : '0;

  fcf_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .coef_i     (coef_q_r),
    .sample_i   (mac_sample),
    .shift_i    (result_shift_r),
    .prod_vld_o (prod_vld),
    .filtered_o (mac_filtered),
    .sat_o      (mac_sat)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered_r <= mac_filtered;
      out_last_r     <= last_flag;
      out_sat_r      <= mac_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_filtered    = out_filtered_r;
  assign out_last_result = out_last_r;
  assign out_saturated   = out_sat_r;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && out_stall) |=> (state_r == ST_EMIT))
    else $error("result register overwritten while stalled");

  // The final beat of a stream leaves the delay line cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_flag) |=> (dly_vld_r == '0))
    else $error("delay line not cleared after the final beat");

  // The tap walk stays within the taps in use.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (iss_r < taps_r))
    else $error("tap walk beyond taps in use");

  // The tail never outlasts the taps in use.
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (tail_r < taps_r))
    else $error("tail count beyond taps in use");

endmodule
